### hdl/ksst_pkg.sv
// Package for the knob smoothing / soft takeover block.
// Holds shared widths, request codes and the structs passed between modules.
// No dependencies.
package ksst_pkg;

   localparam int NUM_KNOBS_DEF   = 2;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int RAW_BITS   = 12;
   localparam int POS_BITS   = 7;
   localparam int SENT_BITS  = 8;

   localparam logic [POS_BITS-1:0]  POS_MAX      = 7'd127;
   localparam logic [SENT_BITS-1:0] NOTHING_SENT = 8'd255;

   // request type codes
   localparam logic REQ_SAMPLE  = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // per-knob state other than the running average
   typedef struct packed {
      logic [POS_BITS-1:0]  position;
      logic [SENT_BITS-1:0] last_sent;
      logic                 holding;
      logic                 seeded;
   } knob_ctrl_type;

   // one result transaction
   typedef struct packed {
      logic                write_strobe;
      logic [POS_BITS-1:0] write_value;
      logic [POS_BITS-1:0] position;
      logic                pickup_held;
   } knob_result_type;

endpackage

### hdl/ksst_knob_unit.sv
// Combinational update of one knob: smoothing, quantization, hysteresis,
// soft pickup and write strobe. Depends on ksst_pkg.
module ksst_knob_unit #(
   parameter int SAMPLE_BITS = ksst_pkg::SAMPLE_BITS_DEF
) (
   input  logic [ksst_pkg::RAW_BITS-1:0] raw_sample,
   input  logic [ksst_pkg::POS_BITS-1:0] stored_param,
   input  logic [SAMPLE_BITS-1:0]        average,
   input  ksst_pkg::knob_ctrl_type       ctrl,
   output logic [SAMPLE_BITS-1:0]        average_next,
   output ksst_pkg::knob_ctrl_type       ctrl_next,
   output ksst_pkg::knob_result_type     result
);

   logic [SAMPLE_BITS-1:0]        raw;
   logic [SAMPLE_BITS-1:0]        base;
   logic [SAMPLE_BITS+1:0]        sum;
   logic [ksst_pkg::POS_BITS-1:0] q;
   logic [ksst_pkg::POS_BITS-1:0] v;
   logic [ksst_pkg::POS_BITS:0]   q_w, prev_w, v_w, cur_w;
   logic                          jump, crossed, moved, hold_next, strobe;

   always_comb begin
      raw  = SAMPLE_BITS'(raw_sample);
      // first sample seeds the average with the reading
      base = ctrl.seeded ? average : raw;
      sum  = ({2'b00, base} << 1) + {2'b00, base} + {2'b00, raw};
      average_next = sum[SAMPLE_BITS+1:2];
      q = average_next[SAMPLE_BITS-1 -: ksst_pkg::POS_BITS];

      q_w    = {1'b0, q};
      prev_w = {1'b0, ctrl.position};
      cur_w  = {1'b0, stored_param};

      // +/-1 hysteresis, end stops always pass
      jump = (q_w > prev_w + 1'b1) || (q_w + 1'b1 < prev_w) ||
             (q == '0) || (q == ksst_pkg::POS_MAX);
      v    = jump ? q : ctrl.position;
      v_w  = {1'b0, v};

      crossed = ((prev_w <= cur_w) && (v_w >= cur_w)) ||
                ((prev_w >= cur_w) && (v_w <= cur_w));
      moved   = (v_w > prev_w + 1'b1) || (prev_w > v_w + 1'b1);
      hold_next = ctrl.holding ||
                  (moved && (crossed || (v == '0) || (v == ksst_pkg::POS_MAX)));
      strobe  = hold_next && ({1'b0, v} != ctrl.last_sent);

      ctrl_next.position  = v;
      ctrl_next.last_sent = strobe ? {1'b0, v} : ctrl.last_sent;
      ctrl_next.holding   = hold_next;
      ctrl_next.seeded    = 1'b1;

      result.write_strobe = strobe;
      result.write_value  = strobe ? v : '0;
      result.position     = v;
      result.pickup_held  = hold_next;
   end

endmodule

### hdl/knob_smoothing_soft_takeover.sv
// Path from request acceptance to response: input register, then result register.
// Throughput: one transaction per cycle, including
// back-to-back samples on the same knob; a stalled response holds the input register.
// Reset (synchronous, active high) clears both valids and all knob state;
// last_sent resets to 255 (nothing sent).
// Top level of the knob smoothing / soft takeover block. Uses ksst_pkg, ksst_knob_unit.
module knob_smoothing_soft_takeover #(
   parameter int NUM_KNOBS   = ksst_pkg::NUM_KNOBS_DEF,
   parameter int SAMPLE_BITS = ksst_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic                          req_knob_index,
   input  logic [ksst_pkg::RAW_BITS-1:0] req_raw_sample,
   input  logic [ksst_pkg::POS_BITS-1:0] req_stored_param,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_write_strobe,
   output logic [ksst_pkg::POS_BITS-1:0] rsp_write_value,
   output logic [ksst_pkg::POS_BITS-1:0] rsp_position,
   output logic                          rsp_pickup_held
);

   localparam int IDX_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

   // input stage
   logic                          s1_valid_ff;
   logic                          s1_type_ff;
   logic                          s1_knob_index_ff;
   logic [ksst_pkg::RAW_BITS-1:0] s1_raw_sample_ff;
   logic [ksst_pkg::POS_BITS-1:0] s1_stored_param_ff;

   // result stage
   logic                          rsp_valid_ff;
   ksst_pkg::knob_result_type     rsp_ff, rsp_in;

   // knob state
   logic [SAMPLE_BITS-1:0]        average_ff  [NUM_KNOBS];
   logic [ksst_pkg::POS_BITS-1:0] position_ff [NUM_KNOBS];
   logic [ksst_pkg::SENT_BITS-1:0] last_sent_ff [NUM_KNOBS];
   logic [NUM_KNOBS-1:0]          holding_ff;
   logic [NUM_KNOBS-1:0]          seeded_ff;

   logic                          advance, is_release, in_range, do_update;
   logic [IDX_W-1:0]              sel;
   ksst_pkg::knob_ctrl_type       ctrl_cur, ctrl_in;
   logic [SAMPLE_BITS-1:0]        average_in;
   ksst_pkg::knob_result_type     unit_result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign is_release = (s1_type_ff == ksst_pkg::REQ_RELEASE);
   assign in_range   = (32'(s1_knob_index_ff) < NUM_KNOBS);
   assign sel        = in_range ? IDX_W'(s1_knob_index_ff) : '0;
   assign do_update  = advance && !is_release && in_range;

   always_comb begin
      ctrl_cur.position  = position_ff[sel];
      ctrl_cur.last_sent = last_sent_ff[sel];
      ctrl_cur.holding   = holding_ff[sel];
      ctrl_cur.seeded    = seeded_ff[sel];
   end

   ksst_knob_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_knob (
      .raw_sample   (s1_raw_sample_ff),
      .stored_param (s1_stored_param_ff),
      .average      (average_ff[sel]),
      .ctrl         (ctrl_cur),
      .average_next (average_in),
      .ctrl_next    (ctrl_in),
      .result       (unit_result)
   );

   always_comb begin
      rsp_in = '0;
      if (is_release) begin
         rsp_in.position = in_range ? ctrl_cur.position : '0;
      end else if (in_range) begin
         rsp_in = unit_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         holding_ff   <= '0;
         seeded_ff    <= '0;
         for (int k = 0; k < NUM_KNOBS; k++) begin
            average_ff[k]   <= '0;
            position_ff[k]  <= '0;
            last_sent_ff[k] <= ksst_pkg::NOTHING_SENT;
         end
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && is_release) begin
            holding_ff <= '0;
         end
         if (do_update) begin
            average_ff[sel]   <= average_in;
            position_ff[sel]  <= ctrl_in.position;
            last_sent_ff[sel] <= ctrl_in.last_sent;
            holding_ff[sel]   <= ctrl_in.holding;
            seeded_ff[sel]    <= ctrl_in.seeded;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_type_ff         <= req_type;
         s1_knob_index_ff   <= req_knob_index;
         s1_raw_sample_ff   <= req_raw_sample;
         s1_stored_param_ff <= req_stored_param;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_strobe = rsp_ff.write_strobe;
   assign rsp_write_value  = rsp_ff.write_value;
   assign rsp_position     = rsp_ff.position;
   assign rsp_pickup_held  = rsp_ff.pickup_held;

endmodule

### hdl/ksst_checker.sv
// Port-level checks for knob_smoothing_soft_takeover, bound to the top level.
// Depends on ksst_pkg for widths.
module ksst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_write_strobe,
   input logic [ksst_pkg::POS_BITS-1:0] rsp_write_value,
   input logic [ksst_pkg::POS_BITS-1:0] rsp_position,
   input logic                          rsp_pickup_held
);

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_strobe) &&
      $stable(rsp_write_value) && $stable(rsp_position) && $stable(rsp_pickup_held))
      else $error("response changed while stalled");

   // nothing emerges right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the result register empty the input side can always take a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // only a held knob may write
   a_strobe_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_strobe |-> rsp_pickup_held)
      else $error("write strobe without pickup");

   // strobed value is the knob position, unstrobed value is zero
   a_strobe_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_strobe ? (rsp_write_value == rsp_position)
                                      : (rsp_write_value == '0)))
      else $error("write value inconsistent with strobe");

endmodule

bind knob_smoothing_soft_takeover ksst_checker u_ksst_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for knob_smoothing_soft_takeover.
// Drives sample and release transactions, predicts every response in step, and
// compares field by field. Depends on ksst_pkg and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KNOBS    = ksst_pkg::NUM_KNOBS_DEF;
   localparam int SMP_BITS = ksst_pkg::SAMPLE_BITS_DEF;
   localparam int LIMIT    = 100000;
   localparam int N_ITEMS  = 450;
   localparam int RAW_TOP  = (1 << ksst_pkg::RAW_BITS) - 1;

   typedef struct {
      logic                          kind;
      logic                          knob;
      logic [ksst_pkg::RAW_BITS-1:0] raw;
      logic [ksst_pkg::POS_BITS-1:0] param;
      bit                            drain;   // sender waits here until all responses are in
   } knob_req_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_type = ksst_pkg::REQ_SAMPLE;
   logic                          req_knob_index = 1'b0;
   logic [ksst_pkg::RAW_BITS-1:0] req_raw_sample = '0;
   logic [ksst_pkg::POS_BITS-1:0] req_stored_param = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_write_strobe;
   logic [ksst_pkg::POS_BITS-1:0] rsp_write_value;
   logic [ksst_pkg::POS_BITS-1:0] rsp_position;
   logic                          rsp_pickup_held;

   knob_smoothing_soft_takeover DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_knob_index   (req_knob_index),
      .req_raw_sample   (req_raw_sample),
      .req_stored_param (req_stored_param),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_strobe (rsp_write_strobe),
      .rsp_write_value  (rsp_write_value),
      .rsp_position     (rsp_position),
      .rsp_pickup_held  (rsp_pickup_held)
   );

   always #1 clock = ~clock;

   // predicted knob state
   logic [SMP_BITS-1:0]            avg_mem    [KNOBS];
   logic [ksst_pkg::POS_BITS-1:0]  pos_mem    [KNOBS];
   logic [ksst_pkg::SENT_BITS-1:0] sent_mem   [KNOBS];
   bit                             held_mem   [KNOBS];
   bit                             seeded_mem [KNOBS];

   knob_req_type              pending_q[$];
   ksst_pkg::knob_result_type knob_rsp_q[$];

   int cycle_cnt    = 0;
   int issued_cnt   = 0;
   int accepted_cnt = 0;
   int rsp_cnt      = 0;
   int err_cnt      = 0;
   int strobe_cnt   = 0;
   int release_cnt  = 0;
   int pickup_cnt   = 0;

   // Smoothing, quantize, hysteresis and soft pickup for one accepted transaction.
   function automatic ksst_pkg::knob_result_type track_knob(
         input logic kind, input logic knob,
         input logic [ksst_pkg::RAW_BITS-1:0] raw,
         input logic [ksst_pkg::POS_BITS-1:0] param);
      ksst_pkg::knob_result_type res;
      logic [SMP_BITS+1:0] sum;
      int q, prev, v, cur;
      bit crossed, moved;
      res = '0;
      if (kind == ksst_pkg::REQ_RELEASE) begin
         for (int k = 0; k < KNOBS; k++)
            held_mem[k] = 1'b0;
         res.position = pos_mem[knob];
         release_cnt++;
         return res;
      end
      if (!seeded_mem[knob]) begin
         avg_mem[knob]    = raw[SMP_BITS-1:0];
         seeded_mem[knob] = 1'b1;
      end
      sum = {2'b00, avg_mem[knob]} * 2'd3 + raw[SMP_BITS-1:0];
      avg_mem[knob] = sum[SMP_BITS+1:2];
      q = int'(avg_mem[knob]) >> (SMP_BITS - ksst_pkg::POS_BITS);
      if (q > int'(ksst_pkg::POS_MAX))
         q = int'(ksst_pkg::POS_MAX);
      prev = int'(pos_mem[knob]);
      cur  = int'(param);
      if (q > prev + 1 || q + 1 < prev || q == 0 || q == int'(ksst_pkg::POS_MAX))
         pos_mem[knob] = q[ksst_pkg::POS_BITS-1:0];
      v = int'(pos_mem[knob]);
      if (!held_mem[knob]) begin
         crossed = (prev <= cur && v >= cur) || (prev >= cur && v <= cur);
         moved   = (v > prev + 1) || (prev > v + 1);
         if (moved && (crossed || v == 0 || v == int'(ksst_pkg::POS_MAX))) begin
            held_mem[knob] = 1'b1;
            pickup_cnt++;
         end
      end
      if (held_mem[knob] && v != int'(sent_mem[knob])) begin
         sent_mem[knob]   = v[ksst_pkg::SENT_BITS-1:0];
         res.write_strobe = 1'b1;
         res.write_value  = pos_mem[knob];
         strobe_cnt++;
      end
      res.position    = pos_mem[knob];
      res.pickup_held = held_mem[knob];
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         err_cnt++;
         $display("%0t tb_top: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic add_req(input logic kind, input logic knob, input int raw, input int param);
      knob_req_type t;
      t.kind  = kind;
      t.knob  = knob;
      t.raw   = raw[ksst_pkg::RAW_BITS-1:0];
      t.param = param[ksst_pkg::POS_BITS-1:0];
      t.drain = 1'b0;
      pending_q.push_back(t);
   endtask

   task automatic add_drain();
      knob_req_type t;
      t = '{kind: ksst_pkg::REQ_SAMPLE, knob: 1'b0, raw: '0, param: '0, drain: 1'b1};
      pending_q.push_back(t);
   endtask

   // Response checking and prediction share one process: pop before push.
   always @(posedge clock) begin : check_rsp
      ksst_pkg::knob_result_type want, got;
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
         $display("%0t tb_top: timeout, %0d responses outstanding", $time, knob_rsp_q.size());
         $display("tb_top: done, errors");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_write_strobe, rsp_write_value, rsp_position, rsp_pickup_held};
            rsp_cnt++;
            if (knob_rsp_q.size() == 0) begin
               err_cnt++;
               $display("%0t tb_top: unexpected response, actual %p", $time, got);
            end else begin
               want = knob_rsp_q.pop_front();
               check_field("write_strobe", want.write_strobe, got.write_strobe);
               check_field("write_value", want.write_value, got.write_value);
               check_field("position", want.position, got.position);
               check_field("pickup_held", want.pickup_held, got.pickup_held);
            end
         end
         if (req_valid && req_ready) begin
            knob_rsp_q.push_back(track_knob(req_type, req_knob_index, req_raw_sample,
                                            req_stored_param));
            accepted_cnt++;
         end
      end
   end

   // Request driver: one request offered at a time, random gap after each.
   int gap_left = 0;
   always @(negedge clock) begin : drive_req
      knob_req_type t;
      logic         nxt_valid;
      bit           quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && accepted_cnt != issued_cnt)) begin
         nxt_valid = 1'b0;
         quiet = ((issued_cnt / 60) % 4) == 1;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_q.size() > 0) begin
            if (pending_q[0].drain) begin
               if (knob_rsp_q.size() == 0)
                  void'(pending_q.pop_front());
            end else begin
               t = pending_q.pop_front();
               req_type         <= t.kind;
               req_knob_index   <= t.knob;
               req_raw_sample   <= t.raw;
               req_stored_param <= t.param;
               nxt_valid = 1'b1;
               issued_cnt++;
               gap_left = quiet ? 0 : $urandom_range(0, 6);
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // Response acceptor: random stall after each transaction, one long hold-off.
   int  stall_left = 0;
   int  long_left  = 0;
   bit  long_done  = 1'b0;
   int  rsp_seen   = 0;
   always @(negedge clock) begin : drive_rsp
      bit quiet;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         quiet = ((rsp_cnt / 50) % 4) == 3;
         if (!long_done && rsp_cnt >= 200) begin
            long_left = 80;
            long_done = 1'b1;
         end
         if (rsp_cnt != rsp_seen) begin
            rsp_seen   = rsp_cnt;
            stall_left = quiet ? 0 : $urandom_range(0, 6);
         end
         if (long_left > 0) begin
            long_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int  n, knob, param, start, stop, len, raw, r, wait_cnt;
      for (int k = 0; k < KNOBS; k++) begin
         avg_mem[k]    = '0;
         pos_mem[k]    = '0;
         sent_mem[k]   = ksst_pkg::NOTHING_SENT;
         held_mem[k]   = 1'b0;
         seeded_mem[k] = 1'b0;
      end

      // directed: releases from reset, end stops, pickup by crossing and by end stop
      add_req(ksst_pkg::REQ_RELEASE, 1'b0, 0, 0);
      add_req(ksst_pkg::REQ_RELEASE, 1'b1, RAW_TOP, 127);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b0, 0, 64);
      repeat (4) add_req(ksst_pkg::REQ_SAMPLE, 1'b0, RAW_TOP, 64);
      add_req(ksst_pkg::REQ_RELEASE, 1'b0, 0, 0);
      repeat (2) add_req(ksst_pkg::REQ_SAMPLE, 1'b0, RAW_TOP, 127);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b1, RAW_TOP, 0);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b1, RAW_TOP, 0);
      add_req(ksst_pkg::REQ_RELEASE, 1'b1, 0, 0);
      repeat (4) add_req(ksst_pkg::REQ_SAMPLE, 1'b1, 0, 127);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b0, 3200, 100);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b0, 3250, 100);
      add_req(ksst_pkg::REQ_SAMPLE, 1'b0, 3180, 100);
      repeat (2) add_req(ksst_pkg::REQ_SAMPLE, 1'b1, 0, 0);
      add_req(ksst_pkg::REQ_RELEASE, 1'b0, 0, 0);
      add_drain();

      // random: mostly knob sweeps with jitter, some holds, noise and releases
      n = 23;
      while (n < N_ITEMS) begin
         r = $urandom_range(0, 99);
         if (n >= 150 && n < 160 && r < 50) begin
            add_drain();
         end
         if (r < 6) begin
            add_req(ksst_pkg::REQ_RELEASE, 1'($urandom_range(0, 1)),
                    $urandom_range(0, RAW_TOP), $urandom_range(0, 127));
            n++;
         end else if (r < 14) begin
            add_req(ksst_pkg::REQ_SAMPLE, 1'($urandom_range(0, 1)),
                    $urandom_range(0, RAW_TOP), $urandom_range(0, 127));
            n++;
         end else begin
            knob  = $urandom_range(0, 1);
            r     = $urandom_range(0, 99);
            param = r < 15 ? 0 : r < 30 ? 127 : $urandom_range(0, 127);
            start = $urandom_range(0, RAW_TOP);
            r     = $urandom_range(0, 99);
            stop  = r < 20 ? 0 : r < 40 ? RAW_TOP : r < 60 ? start : $urandom_range(0, RAW_TOP);
            len   = $urandom_range(3, 12);
            for (int j = 1; j <= len; j++) begin
               raw = start + (stop - start) * j / len + int'($urandom_range(0, 96)) - 48;
               if (raw < 0) raw = 0;
               if (raw > RAW_TOP) raw = RAW_TOP;
               add_req(ksst_pkg::REQ_SAMPLE, 1'(knob), raw, param);
               n++;
            end
         end
      end
      add_drain();
      add_req(ksst_pkg::REQ_RELEASE, 1'b1, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || accepted_cnt != issued_cnt || knob_rsp_q.size() > 0)
         @(negedge clock);
      wait_cnt = 0;
      while (wait_cnt < 10) begin
         @(negedge clock);
         wait_cnt++;
      end

      $display("tb_top: %0d transactions in, %0d out, %0d releases", accepted_cnt, rsp_cnt,
               release_cnt);
      $display("tb_top: %0d pickups, %0d write strobes", pickup_cnt, strobe_cnt);
      if (err_cnt == 0 && knob_rsp_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
